// File: design/rgbh_pkg.sv
// Shared types, widths and constant tables for the RGB to HSI hue converter.
// Holds the cosine tables used by every search cell; depends on nothing.
package rgbh_pkg;

  localparam int COLOR_BITS = 8;

  localparam int DIFF_W = COLOR_BITS + 1;
  localparam int N2_W   = COLOR_BITS + 2;
  localparam int AN_W   = COLOR_BITS + 1;
  localparam int NSQ_W  = 2 * AN_W;
  localparam int SUM_W  = 2 * DIFF_W + 1;
  localparam int DSQ_W  = 2 * COLOR_BITS + 1;
  localparam int SQ_SHIFT = 28;
  localparam int CSQ_W  = 31;
  localparam int LSQ_W  = CSQ_W + DSQ_W;

  localparam int IDX_W     = 8;
  localparam int ROM_DEPTH = 1 << IDX_W;
  localparam int NUM_CELLS = IDX_W;
  localparam int COS_W     = 16;
  localparam int HUE_W     = 9;

  localparam logic [IDX_W-1:0] ANGLE_MAX = IDX_W'(180);
  localparam logic [IDX_W-1:0] PROBE_TOP = IDX_W'(1) << (IDX_W - 1);
  localparam logic [HUE_W-1:0] HUE_GRAY  = HUE_W'(90);
  localparam logic [HUE_W-1:0] HUE_WRAP  = HUE_W'(359);

  localparam longint COS_ONE    = 16384;
  localparam longint COS_HALF   = 8192;
  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint Q30_HALF   = 64'sd536870912;
  localparam longint COS1_Q30   = 64'sd1073578288;
  localparam longint SIN1_Q30   = 64'sd18739379;
  localparam longint COS_SCALE  = 65536;
  localparam longint COS_ROUND  = 32768;

  typedef logic signed [COS_W-1:0] cos_rom_t [ROM_DEPTH];
  typedef logic [CSQ_W-1:0] csq_rom_t [ROM_DEPTH];

  typedef struct packed {
    logic [IDX_W-1:0] res;
    logic [IDX_W-1:0] probe;
    logic             blue_gt;
    logic             gray;
    logic             n_pos;
    logic             n_neg;
    logic [DSQ_W-1:0] dsq;
    logic [NSQ_W-1:0] nsq;
  } hue_tok_t;

  // Cosine of each whole degree in Q1.14, built by repeated one-degree rotation.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint c;
    longint s;
    longint nc;
    longint ns;
    c = Q30_ONE;
    s = 0;
    for (int t = 0; t < ROM_DEPTH; t++) begin
      rom[t] = COS_W'(-COS_ONE);
    end
    rom[0] = COS_W'(COS_ONE);
    for (int t = 1; t <= 90; t++) begin
      nc = (c * COS1_Q30 - s * SIN1_Q30 + Q30_HALF) / Q30_ONE;
      ns = (s * COS1_Q30 + c * SIN1_Q30 + Q30_HALF) / Q30_ONE;
      c = nc;
      s = ns;
      rom[t] = (c > 0) ? COS_W'((c + COS_ROUND) / COS_SCALE) : '0;
    end
    rom[60] = COS_W'(COS_HALF);
    rom[90] = '0;
    for (int t = 0; t < 90; t++) begin
      rom[180 - t] = -rom[t];
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // Four times the squared cosine, so each cell needs a single multiply.
  function automatic csq_rom_t build_csq_rom();
    csq_rom_t rom;
    longint cq;
    for (int t = 0; t < ROM_DEPTH; t++) begin
      cq = longint'(COS_ROM[t]);
      rom[t] = CSQ_W'(4 * cq * cq);
    end
    return rom;
  endfunction

  localparam csq_rom_t CSQ_ROM = build_csq_rom();

endpackage

// File: design/rgbh_prep.sv
// Front end of the hue converter: color differences, squared terms and signs.
// Two pipeline stages with their own valid bits; uses rgbh_pkg.
module rgbh_prep
  import rgbh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] blue,
  output logic                  tok_valid,
  input  logic                  tok_ready,
  output hue_tok_t              tok
);

  logic                     v1;
  logic                     adv1;
  logic                     adv2;
  logic signed [DIFF_W-1:0] d1;
  logic signed [DIFF_W-1:0] d2;
  logic signed [DIFF_W-1:0] d3;
  logic                     bgt1;

  logic signed [SUM_W-1:0] d1_x;
  logic signed [SUM_W-1:0] d2_x;
  logic signed [SUM_W-1:0] d3_x;
  logic signed [SUM_W-1:0] sum;
  logic signed [N2_W-1:0]  n2;
  logic [AN_W-1:0]         an;
  hue_tok_t                tok_next;

  assign adv2     = !tok_valid || tok_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      d1   <= DIFF_W'($signed({1'b0, red})) - DIFF_W'($signed({1'b0, green}));
      d2   <= DIFF_W'($signed({1'b0, red})) - DIFF_W'($signed({1'b0, blue}));
      d3   <= DIFF_W'($signed({1'b0, green})) - DIFF_W'($signed({1'b0, blue}));
      bgt1 <= blue > green;
    end
  end

  always_comb begin
    d1_x = SUM_W'(d1);
    d2_x = SUM_W'(d2);
    d3_x = SUM_W'(d3);
    sum  = d1_x * d1_x + d2_x * d3_x;
    n2   = N2_W'(d1) + N2_W'(d2);
    an   = (n2 < 0) ? AN_W'(-n2) : AN_W'(n2);
    tok_next.res     = '0;
    tok_next.probe   = PROBE_TOP;
    tok_next.blue_gt = bgt1;
    tok_next.gray    = (sum == '0);
    tok_next.n_pos   = (n2 > 0);
    tok_next.n_neg   = (n2 < 0);
    tok_next.dsq     = DSQ_W'(sum);
    tok_next.nsq     = NSQ_W'(an) * NSQ_W'(an);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (adv2) begin
      tok_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      tok <= tok_next;
    end
  end

endmodule

// File: design/rgbh_cell.sv
// One step of the angle search: tests one bit of the angle against the cosine table.
// Two stages, multiply then compare; uses rgbh_pkg.
module rgbh_cell
  import rgbh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  hue_tok_t in_tok,
  output logic     out_valid,
  input  logic     out_ready,
  output hue_tok_t out_tok
);

  logic             va;
  logic             adv_a;
  logic             adv_b;
  logic [IDX_W-1:0] cand;
  hue_tok_t         a_tok;
  logic [IDX_W-1:0] a_cand;
  logic             a_fit;
  logic             a_cpos;
  logic             a_cneg;
  logic [LSQ_W-1:0] a_lsq;

  logic [LSQ_W-1:0] rsq;
  logic             gt;
  logic             eq;
  logic             take;
  hue_tok_t         tok_next;

  assign adv_b    = !out_valid || out_ready;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a;
  assign cand     = in_tok.res | in_tok.probe;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_tok  <= in_tok;
      a_cand <= cand;
      a_fit  <= cand <= ANGLE_MAX;
      a_cpos <= COS_ROM[cand] > 0;
      a_cneg <= COS_ROM[cand] < 0;
      a_lsq  <= LSQ_W'(CSQ_ROM[cand]) * LSQ_W'(in_tok.dsq);
    end
  end

  always_comb begin
    rsq = LSQ_W'(a_tok.nsq) << SQ_SHIFT;
    if ((a_cpos != a_tok.n_pos) || (a_cneg != a_tok.n_neg) || (!a_cpos && !a_cneg)) begin
      gt = (a_cpos && !a_tok.n_pos) || (!a_cpos && !a_cneg && a_tok.n_neg);
      eq = (a_cpos == a_tok.n_pos) && (a_cneg == a_tok.n_neg);
    end else if (a_cpos) begin
      gt = a_lsq > rsq;
      eq = a_lsq == rsq;
    end else begin
      gt = a_lsq < rsq;
      eq = a_lsq == rsq;
    end
    take = a_fit && (a_tok.blue_gt ? gt : (gt || eq));
    tok_next       = a_tok;
    tok_next.res   = take ? a_cand : a_tok.res;
    tok_next.probe = a_tok.probe >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_b) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      out_tok <= tok_next;
    end
  end

endmodule

// File: design/rgb_to_hsi_hue_core.sv
// Pipeline: an accepted input beat passes two front-end stages, eight search cells of
// two stages each and one output register before it leaves as its output beat.
// Throughput: one pixel per cycle while out_ready stays high; every stage has its own valid bit, so bubbles close up.
// Reset: synchronous, active high; clears all valid bits. The data registers are not reset.
// Top level of the RGB to HSI hue converter; instantiates rgbh_prep and rgbh_cell,
// and uses rgbh_pkg.
module rgb_to_hsi_hue_core
  import rgbh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [HUE_W-1:0]      hue_degrees
);

  logic     chain_valid [NUM_CELLS+1];
  logic     chain_ready [NUM_CELLS+1];
  hue_tok_t chain_tok   [NUM_CELLS+1];

  logic             last_valid;
  logic             last_ready;
  hue_tok_t         last_tok;
  logic [HUE_W-1:0] hue_next;

  rgbh_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .tok_valid (chain_valid[0]),
    .tok_ready (chain_ready[0]),
    .tok       (chain_tok[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rgbh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_tok    (chain_tok[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_tok   (chain_tok[i+1])
    );
  end

  assign last_valid = chain_valid[NUM_CELLS];
  assign last_tok   = chain_tok[NUM_CELLS];
  assign last_ready = !out_valid || out_ready;
  assign chain_ready[NUM_CELLS] = last_ready;

  always_comb begin
    if (last_tok.gray) begin
      hue_next = HUE_GRAY;
    end else if (last_tok.blue_gt) begin
      hue_next = HUE_WRAP - HUE_W'(last_tok.res);
    end else begin
      hue_next = HUE_W'(last_tok.res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_ready) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready) begin
      hue_degrees <= hue_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid set right after reset");

  a_search_done: assert property (@(posedge clk) disable iff (rst)
    last_valid |-> last_tok.probe == '0)
    else $error("angle search left untested bits");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    last_valid && !last_tok.gray |-> last_tok.res <= ANGLE_MAX)
    else $error("searched angle beyond 180 degrees");
`endif

endmodule

// File: bench/hue_checker.sv
`timescale 1ns / 100ps
// Hue checker for rgb_to_hsi_hue_core: watches the pixel and hue channels, predicts each
// hue with its own fixed-point cosine search and counts mismatches. Uses rgbh_pkg widths.
module hue_checker
  import rgbh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] blue,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [HUE_W-1:0]      hue_degrees,
  output int                    mismatches,
  output int                    pending_hues,
  output int                    hues_checked
);

  localparam longint UNIT_Q30     = 64'sd1073741824;
  localparam longint HALF_Q30     = 64'sd536870912;
  localparam longint STEP_COS_Q30 = 64'sd1073578288;
  localparam longint STEP_SIN_Q30 = 64'sd18739379;
  localparam longint Q30_TO_Q14   = 65536;
  localparam int     ONE_Q14      = 16384;
  localparam int     RATIO_SHIFT  = 28;
  localparam int     MAX_ANGLE    = 180;
  localparam int     RIGHT_ANGLE  = 90;
  localparam int     SIXTY_DEG    = 60;
  localparam int     FULL_TURN    = 360;
  localparam logic [HUE_W-1:0] GRAY_HUE = HUE_W'(90);

  typedef struct {
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
    logic [HUE_W-1:0]      hue;
  } hue_entry_t;

  int         cos_q14 [0:MAX_ANGLE];
  hue_entry_t hue_queue [$];

  initial begin : build_cosines
    longint c;
    longint s;
    longint nc;
    longint ns;
    c = UNIT_Q30;
    s = 0;
    cos_q14[0] = ONE_Q14;
    for (int t = 1; t <= RIGHT_ANGLE; t++) begin
      nc = (c * STEP_COS_Q30 - s * STEP_SIN_Q30 + HALF_Q30) / UNIT_Q30;
      ns = (s * STEP_COS_Q30 + c * STEP_SIN_Q30 + HALF_Q30) / UNIT_Q30;
      c = nc;
      s = ns;
      cos_q14[t] = (c > 0) ? int'((c + Q30_TO_Q14 / 2) / Q30_TO_Q14) : 0;
    end
    cos_q14[SIXTY_DEG] = ONE_Q14 / 2;
    cos_q14[RIGHT_ANGLE] = 0;
    for (int t = 0; t < RIGHT_ANGLE; t++) begin
      cos_q14[MAX_ANGLE - t] = -cos_q14[t];
    end
  end

  // Sign of cq/2^14 - n2/(2*sqrt(d)) for d > 0, decided on squares without a root.
  function automatic int cos_side(input int cq, input longint n2, input longint d);
    int     sl;
    int     sr;
    longint ac;
    longint an;
    longint lhs;
    longint rhs;
    sl = (cq > 0) ? 1 : ((cq < 0) ? -1 : 0);
    sr = (n2 > 0) ? 1 : ((n2 < 0) ? -1 : 0);
    if (sl != sr || sl == 0) begin
      return (sl > sr) ? 1 : ((sl < sr) ? -1 : 0);
    end
    ac = (cq < 0) ? -cq : cq;
    an = (n2 < 0) ? -n2 : n2;
    lhs = 4 * ac * ac * d;
    rhs = (an * an) << RATIO_SHIFT;
    if (lhs == rhs) begin
      return 0;
    end
    return ((lhs > rhs) == (sl > 0)) ? 1 : -1;
  endfunction

  function automatic logic [HUE_W-1:0] predict_hue(input logic [COLOR_BITS-1:0] r,
                                                   input logic [COLOR_BITS-1:0] g,
                                                   input logic [COLOR_BITS-1:0] b);
    longint rv;
    longint gv;
    longint bv;
    longint dsq;
    longint n2;
    int     t;
    rv = r;
    gv = g;
    bv = b;
    dsq = (rv - gv) * (rv - gv) + (rv - bv) * (gv - bv);
    n2 = (rv - gv) + (rv - bv);
    if (dsq <= 0) begin
      return GRAY_HUE;
    end
    if (bv <= gv) begin
      t = MAX_ANGLE;
      while (t > 0 && cos_side(cos_q14[t], n2, dsq) < 0) t--;
      return HUE_W'(t);
    end
    t = 0;
    while (t < MAX_ANGLE && cos_side(cos_q14[t], n2, dsq) > 0) t++;
    if (t == 0) begin
      t = 1;
    end
    return HUE_W'(FULL_TURN - t);
  endfunction

  always @(posedge clk) begin : watch_beats
    hue_entry_t head;
    hue_entry_t entry;
    if (rst) begin
      hue_queue.delete();
      mismatches <= 0;
      pending_hues <= 0;
      hues_checked <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hue_queue.size() == 0) begin
          $display("%0t: unexpected hue beat, expected none, actual %0d",
                   $time, hue_degrees);
          mismatches <= mismatches + 1;
        end else begin
          head = hue_queue.pop_front();
          hues_checked <= hues_checked + 1;
          if (hue_degrees !== head.hue) begin
            $display("%0t: hue of pixel (%0d,%0d,%0d) expected %0d, actual %0d",
                     $time, head.r, head.g, head.b, head.hue, hue_degrees);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        entry.r = red;
        entry.g = green;
        entry.b = blue;
        entry.hue = predict_hue(red, green, blue);
        hue_queue.push_back(entry);
      end
      pending_hues <= hue_queue.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for rgb_to_hsi_hue_core: clock, reset, directed and random pixel stimulus
// with random idling on both channels, and the verdict. Uses rgbh_pkg and hue_checker.
module tb_top;
  import rgbh_pkg::*;

  localparam int RANDOM_PIXELS   = 1880;
  localparam int CALM_PIXELS     = 150;
  localparam int HOLD_OFF_AFTER  = 500;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int BURST_MAX       = 18;
  localparam int READY_RUN_MAX   = 40;
  localparam int RESET_CYCLES    = 8;
  localparam int PHASE_PIXELS    = 100;
  localparam logic [COLOR_BITS-1:0] FULL = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COLOR_BITS-1:0] red = '0;
  logic [COLOR_BITS-1:0] green = '0;
  logic [COLOR_BITS-1:0] blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [HUE_W-1:0]      hue_degrees;

  int mismatches;
  int pending_hues;
  int hues_checked;
  int pixels_accepted = 0;
  int gray_pixels = 0;
  int quiet_cycles = 0;
  int idle_odds = 4;
  bit calm = 1'b0;
  bit hold_off_done = 1'b0;

  always #4 clk = ~clk;

  rgb_to_hsi_hue_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hue_degrees(hue_degrees)
  );

  hue_checker u_hue_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hue_degrees (hue_degrees),
    .mismatches  (mismatches),
    .pending_hues(pending_hues),
    .hues_checked(hues_checked)
  );

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pixels_accepted <= pixels_accepted + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : receiver
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (!hold_off_done && pixels_accepted >= HOLD_OFF_AFTER) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, READY_RUN_MAX)) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [COLOR_BITS-1:0] r,
                            input logic [COLOR_BITS-1:0] g,
                            input logic [COLOR_BITS-1:0] b);
    red <= r;
    green <= g;
    blue <= b;
    in_valid <= 1'b1;
    if (r == g && g == b) gray_pixels++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
    logic [COLOR_BITS-1:0] v;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel('0, '0, '0);
    send_pixel(FULL, FULL, FULL);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(FULL, '0, '0);
    send_pixel('0, FULL, '0);
    send_pixel('0, '0, FULL);
    send_pixel(FULL, FULL, '0);
    send_pixel('0, FULL, FULL);
    send_pixel(FULL, '0, FULL);
    send_pixel(FULL, '0, 8'd1);
    send_pixel(8'd1, '0, '0);
    send_pixel('0, 8'd1, '0);
    send_pixel('0, '0, 8'd1);
    send_pixel('0, 8'd1, 8'd1);
    send_pixel(8'd1, '0, 8'd1);
    send_pixel(8'd1, 8'd1, '0);
    send_pixel(8'd254, FULL, FULL);
    send_pixel(FULL, 8'd254, 8'd254);
    send_pixel(FULL, 8'd128, '0);
    send_pixel('0, 8'd128, FULL);
    send_pixel(8'd200, 8'd100, 8'd101);
    send_pixel(FULL, '0, 8'd128);
    send_pixel(8'hAA, 8'h55, 8'h55);
    send_pixel(8'h55, 8'hAA, 8'hAA);
    send_pixel(8'd85, 8'd170, FULL);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % PHASE_PIXELS == 0) begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 2;
          2: idle_odds = 4;
          default: idle_odds = 8;
        endcase
      end
      if (n == RANDOM_PIXELS - CALM_PIXELS) calm = 1'b1;
      v = COLOR_BITS'($urandom);
      r = COLOR_BITS'($urandom);
      g = COLOR_BITS'($urandom);
      b = COLOR_BITS'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          r = v;
          g = v;
          b = v;
        end
        1: begin
          r = v;
          g = v ^ COLOR_BITS'($urandom_range(0, 3));
          b = v ^ COLOR_BITS'($urandom_range(0, 3));
        end
        2: b = g;
        3: b = g + 1'b1;
        4: begin
          r = $urandom_range(0, 1) ? FULL : '0;
          g = $urandom_range(0, 1) ? FULL : '0;
          b = $urandom_range(0, 1) ? FULL : '0;
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hues != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d pixels converted (%0d gray), %0d hue beats compared.",
             pixels_accepted, gray_pixels, hues_checked);
    $display("Random idling on both sides, one %0d-cycle output hold-off, full rate at the end.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0 && pending_hues == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
